/* src/assert_macros.svh */
// Assertion macros for the byte tokenizer RTL.
// Each macro expects clk and rst_n in the scope that uses it.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every clock edge outside reset.
`define TLBT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that a condition holds in the cycle after a trigger.
`define TLBT_ASSERT_NEXT(lbl, trig, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cons)) else $error(msg);

`endif

/* src/tlbt_pkg.sv */
// Shared types, token kinds and byte classification for the tokenizer.
// No dependencies; used by every module of the block.
package tlbt_pkg;

  typedef struct packed {
    logic space;
    logic digit;
    logic letter;
    logic opchar;
    logic punct;
    logic litchar;
  } cls_t;

  typedef struct packed {
    logic [7:0] ch;
    cls_t       cls;
  } went_t;

  typedef struct packed {
    logic [7:0] ch;
    logic       eot;
    cls_t       cls;
  } in_item_t;

  typedef struct packed {
    logic [4:0]  kind;
    logic [15:0] start;
    logic [15:0] len;
    logic        last;
  } res_t;

  localparam logic [4:0] K_LINE  = 5'd0;
  localparam logic [4:0] K_BLOCK = 5'd1;
  localparam logic [4:0] K_DASH  = 5'd2;
  localparam logic [4:0] K_STR   = 5'd3;
  localparam logic [4:0] K_NUM   = 5'd4;
  localparam logic [4:0] K_SEL   = 5'd5;
  localparam logic [4:0] K_VIR   = 5'd6;
  localparam logic [4:0] K_IDENT = 5'd7;
  localparam logic [4:0] K_LIT   = 5'd14;
  localparam logic [4:0] K_EQ    = 5'd15;
  localparam logic [4:0] K_ARROW = 5'd16;
  localparam logic [4:0] K_COLON = 5'd17;
  localparam logic [4:0] K_SEMI  = 5'd18;
  localparam logic [4:0] K_COMMA = 5'd19;
  localparam logic [4:0] K_LPAR  = 5'd20;
  localparam logic [4:0] K_RPAR  = 5'd21;
  localparam logic [4:0] K_LBRK  = 5'd22;
  localparam logic [4:0] K_RBRK  = 5'd23;
  localparam logic [4:0] K_LBRC  = 5'd24;
  localparam logic [4:0] K_RBRC  = 5'd25;
  localparam logic [4:0] K_ERR   = 5'd26;
  localparam logic [4:0] K_END   = 5'd27;

  localparam logic [2:0] KW_NONE = 3'd0;

  function automatic cls_t classify(input logic [7:0] b);
    cls_t c;
    c.space  = (b == 8'h20) || (b >= 8'h09 && b <= 8'h0D);
    c.digit  = (b >= "0" && b <= "9");
    c.letter = (b >= "a" && b <= "z") || (b >= "A" && b <= "Z") || b == "_" || b == "$";
    c.opchar = b == "=" || b == ":" || b == ";" || b == "," || b == "+" || b == "-" ||
               b == "*" || b == "/" || b == "%" || b == "!" || b == "<" || b == ">" ||
               b == "&" || b == "|" || b == "^" || b == "~" || b == "?";
    c.punct  = b == "(" || b == ")" || b == "[" || b == "]" || b == "{" || b == "}" ||
               b == ";" || b == "," || b == ":";
    c.litchar = c.letter || c.digit || b == "-" || b == "." || b == ":" || b == "@";
    return c;
  endfunction

  // p holds the first ten window bytes, entry 0 in the top byte.
  function automatic logic [2:0] kw_match(input logic [79:0] p, input logic [4:0] f);
    logic [2:0] k;
    k = KW_NONE;
    if (f >= 5'd6 && p[79:32] == "listen") k = 3'd1;
    else if (f >= 5'd8 && p[79:16] == "delegate") k = 3'd2;
    else if (f >= 5'd7 && p[79:24] == "animate") k = 3'd3;
    else if (f >= 5'd6 && p[79:32] == "router") k = 3'd4;
    else if (f >= 5'd10 && p[79:0] == "fileloader") k = 3'd5;
    else if (f >= 5'd4 && p[79:48] == "util") k = 3'd6;
    return k;
  endfunction

  function automatic logic [3:0] kw_len(input logic [2:0] k);
    logic [3:0] l;
    unique case (k)
      3'd1: l = 4'd6;
      3'd2: l = 4'd8;
      3'd3: l = 4'd7;
      3'd4: l = 4'd6;
      3'd5: l = 4'd10;
      3'd6: l = 4'd4;
      default: l = 4'd0;
    endcase
    return l;
  endfunction

  function automatic logic [7:0] delim_ch(input logic [1:0] s);
    logic [7:0] d;
    unique case (s)
      2'd1: d = 8'h27;
      2'd2: d = 8'h60;
      default: d = 8'h22;
    endcase
    return d;
  endfunction

  function automatic logic [15:0] sat16(input logic [31:0] v);
    return (v > 32'd65535) ? 16'hFFFF : v[15:0];
  endfunction

endpackage

/* src/tlbt_front.sv */
// Input side: two-entry item queue that classifies each byte on entry.
// Depends on tlbt_pkg.
module tlbt_front (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [7:0]         in_char_byte,
  input  logic               in_end_of_text,
  output logic               q_valid,
  output tlbt_pkg::in_item_t q_item,
  input  logic               q_pop
);

  tlbt_pkg::in_item_t q_r [2];
  logic       wp_r, wp_nxt;
  logic       rp_r, rp_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       push;

  assign in_ready = (cnt_r != 2'd2);
  assign push     = in_valid && in_ready;
  assign q_valid  = (cnt_r != 2'd0);
  assign q_item   = q_r[rp_r];

  always_comb begin
    wp_nxt  = push ? ~wp_r : wp_r;
    rp_nxt  = q_pop ? ~rp_r : rp_r;
    cnt_nxt = cnt_r + 2'(push) - 2'(q_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wp_r].ch  <= in_char_byte;
      q_r[wp_r].eot <= in_end_of_text;
      q_r[wp_r].cls <= tlbt_pkg::classify(in_char_byte);
    end
  end

endmodule

/* src/tlbt_outq.sv */
// Result side: two-entry token queue toward the output channel.
// Depends on tlbt_pkg.
module tlbt_outq (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  tlbt_pkg::res_t push_res,
  output logic           has_room,
  output logic           out_valid,
  input  logic           out_ready,
  output tlbt_pkg::res_t head
);

  tlbt_pkg::res_t q_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r, cnt_nxt;
  logic       pop;

  assign has_room  = (cnt_r != 2'd2);
  assign out_valid = (cnt_r != 2'd0);
  assign pop       = out_valid && out_ready;
  assign head      = q_r[rp_r];
  assign cnt_nxt   = cnt_r + 2'(push) - 2'(pop);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (pop) rp_r <= ~rp_r;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) q_r[wp_r] <= push_res;
  end

endmodule

/* src/tlbt_back.sv */
// Lexer engine: lookahead window, lexer mode and one tokenizer move per cycle unless stalled by input or results.
// Depends on tlbt_pkg and assert_macros.svh.
`include "assert_macros.svh"

module tlbt_back #(
  parameter int MAX_TEXT  = 65536,
  parameter int LOOKAHEAD = 10
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               q_valid,
  input  tlbt_pkg::in_item_t q_item,
  output logic               q_pop,
  input  logic               res_room,
  output logic               res_push,
  output tlbt_pkg::res_t     res_out
);

  localparam int OW = $clog2(MAX_TEXT + 1);
  localparam int FW = $clog2(LOOKAHEAD + 1);
  localparam int IW = $clog2(LOOKAHEAD);

  typedef enum logic [10:0] {
    M_IDLE  = 11'b00000000001,
    M_LINE  = 11'b00000000010,
    M_BLOCK = 11'b00000000100,
    M_DASH  = 11'b00000001000,
    M_STR   = 11'b00000010000,
    M_NUM   = 11'b00000100000,
    M_SEL   = 11'b00001000000,
    M_VIRWS = 11'b00010000000,
    M_VIRID = 11'b00100000000,
    M_IDENT = 11'b01000000000,
    M_LIT   = 11'b10000000000
  } mode_t;

  mode_t           mode_r, mode_nxt;
  tlbt_pkg::went_t win_r [LOOKAHEAD];
  tlbt_pkg::went_t win_nxt [LOOKAHEAD];
  logic [FW-1:0]   fill_r, fill_nxt;
  logic [OW-1:0]   ts_r, ts_nxt;
  logic [OW-1:0]   cur_r, cur_nxt;
  logic [1:0]      nflags_r, nflags_nxt;
  logic            esc_r, esc_nxt;
  logic [1:0]      delim_r, delim_nxt;
  logic [2:0]      kp_r, kp_nxt;
  logic            fin_r, fin_nxt;
  logic            need_r, need_nxt;
  logic            pend_v_r, pend_v_nxt;
  tlbt_pkg::res_t  pend_r, pend_nxt;

  // effective window after taking a new byte
  tlbt_pkg::went_t win_e [LOOKAHEAD];
  tlbt_pkg::went_t win_s [LOOKAHEAD];
  logic [FW-1:0]   fill_e;
  logic            fin_e, avail;

  // one move
  logic            go, emit;
  logic [3:0]      n;
  logic [4:0]      n_eff;
  logic [4:0]      kind;
  mode_t           mode_s;
  logic [OW-1:0]   ts_s, cur_s;
  logic [1:0]      nflags_s, delim_s;
  logic            esc_s;
  logic [2:0]      kp_s, kw;
  logic [7:0]      c, d, a_ch, z_ch;
  tlbt_pkg::cls_t  cc;
  logic            h1, lit_start;
  logic [79:0]     p;
  logic [OW:0]     sum;

  logic            push_req, push_last, fire;

  always_comb begin
    win_e  = win_r;
    fill_e = fill_r;
    fin_e  = fin_r;
    avail  = 1'b1;
    if (need_r) begin
      avail = q_valid;
      fin_e = q_item.eot;
      if (fill_r < FW'(LOOKAHEAD)) begin
        win_e[fill_r[IW-1:0]].ch  = q_item.ch;
        win_e[fill_r[IW-1:0]].cls = q_item.cls;
        fill_e = fill_r + FW'(1);
      end
    end
  end

  always_comb begin
    for (int i = 0; i < 10; i++) p[79 - 8 * i -: 8] = win_e[i].ch;
    c  = (fill_e != '0) ? win_e[0].ch : 8'h00;
    cc = (fill_e != '0) ? win_e[0].cls : tlbt_pkg::classify(8'h00);
    h1 = (fill_e > FW'(1));
    d  = h1 ? win_e[1].ch : 8'h00;
    kw = tlbt_pkg::kw_match(p, 5'(fill_e));
    lit_start = !cc.digit && !cc.opchar && !cc.punct && !cc.space &&
                c != 8'h22 && c != 8'h27 && c != 8'h60;
    a_ch = (mode_r == M_BLOCK) ? "*" : "}";
    z_ch = (mode_r == M_BLOCK) ? "/" : "}";

    go       = 1'b1;
    emit     = 1'b0;
    n        = 4'd0;
    kind     = tlbt_pkg::K_ERR;
    mode_s   = mode_r;
    ts_s     = ts_r;
    nflags_s = nflags_r;
    esc_s    = esc_r;
    delim_s  = delim_r;
    kp_s     = kp_r;

    unique case (mode_r)
      M_IDLE: begin
        if (fill_e == '0) go = 1'b0;
        else if (cc.space) n = 4'd1;
        else if (fill_e < FW'(LOOKAHEAD) && !fin_e) go = 1'b0;
        else begin
          ts_s = cur_r;
          priority if (c == "/" && h1 && d == "/") begin
            n = 4'd2; mode_s = M_LINE;
          end else if (c == "/" && h1 && d == "*") begin
            n = 4'd2; mode_s = M_BLOCK;
          end else if (c == "-" && h1 && d == "-") begin
            n = 4'd2; mode_s = M_DASH;
          end else if (c == 8'h22 || c == 8'h27 || c == 8'h60) begin
            delim_s = (c == 8'h22) ? 2'd0 : (c == 8'h27) ? 2'd1 : 2'd2;
            esc_s   = 1'b0;
            n       = 4'd1;
            mode_s  = M_STR;
          end else if (cc.digit) begin
            nflags_s = 2'd0; mode_s = M_NUM;
          end else if (c == "{" && h1 && d == "{") begin
            n = 4'd2; mode_s = M_SEL;
          end else if (fill_e >= FW'(3) && c == "v" && d == "i" && win_e[2].ch == "r") begin
            n = 4'd3; mode_s = M_VIRWS;
          end else if (kw != tlbt_pkg::KW_NONE) begin
            n = tlbt_pkg::kw_len(kw); kp_s = kw; mode_s = M_IDENT;
          end else if (lit_start) begin
            if (cc.litchar) mode_s = M_LIT;
            else begin
              n = 4'd1; emit = 1'b1; kind = tlbt_pkg::K_ERR;
            end
          end else if (cc.opchar) begin
            emit = 1'b1;
            if (c == "-" && h1 && d == ">") begin
              n = 4'd2; kind = tlbt_pkg::K_ARROW;
            end else begin
              n = 4'd1;
              kind = (c == "=") ? tlbt_pkg::K_EQ : (c == ":") ? tlbt_pkg::K_COLON :
                     (c == ";") ? tlbt_pkg::K_SEMI : (c == ",") ? tlbt_pkg::K_COMMA :
                     tlbt_pkg::K_ERR;
            end
          end else begin
            n = 4'd1; emit = 1'b1;
            kind = (c == "(") ? tlbt_pkg::K_LPAR : (c == ")") ? tlbt_pkg::K_RPAR :
                   (c == "[") ? tlbt_pkg::K_LBRK : (c == "]") ? tlbt_pkg::K_RBRK :
                   (c == "{") ? tlbt_pkg::K_LBRC : (c == "}") ? tlbt_pkg::K_RBRC :
                   tlbt_pkg::K_ERR;
          end
        end
      end
      M_BLOCK, M_SEL: begin
        kind = (mode_r == M_BLOCK) ? tlbt_pkg::K_BLOCK : tlbt_pkg::K_SEL;
        if (fill_e >= FW'(2)) begin
          if (c == a_ch && win_e[1].ch == z_ch) begin
            n = 4'd2; emit = 1'b1;
          end else n = 4'd1;
        end else if (!fin_e) go = 1'b0;
        else if (fill_e == FW'(1)) n = 4'd1;
        else emit = 1'b1;
      end
      M_LINE, M_DASH, M_STR, M_NUM, M_VIRWS, M_VIRID, M_IDENT, M_LIT: begin
        unique case (mode_r)
          M_LINE:  kind = tlbt_pkg::K_LINE;
          M_DASH:  kind = tlbt_pkg::K_DASH;
          M_STR:   kind = tlbt_pkg::K_STR;
          M_NUM:   kind = tlbt_pkg::K_NUM;
          M_IDENT: kind = (kp_r != tlbt_pkg::KW_NONE) ?
                          tlbt_pkg::K_IDENT + 5'(kp_r) : tlbt_pkg::K_IDENT;
          M_LIT:   kind = tlbt_pkg::K_LIT;
          default: kind = tlbt_pkg::K_VIR;
        endcase
        if (fill_e == '0) begin
          if (!fin_e) go = 1'b0;
          else emit = 1'b1;
        end else begin
          unique case (mode_r)
            M_LINE, M_DASH: begin
              n = 4'd1;
              emit = (c == 8'h0A || c == 8'h0D);
            end
            M_STR: begin
              n = 4'd1;
              if (esc_r) esc_s = 1'b0;
              else if (c == tlbt_pkg::delim_ch(delim_r)) emit = 1'b1;
              else if (c == 8'h5C) esc_s = 1'b1;
            end
            M_NUM: begin
              if (cc.digit || c == "+" || c == "-") n = 4'd1;
              else if (c == "." && !nflags_r[0]) begin
                nflags_s[0] = 1'b1; n = 4'd1;
              end else if ((c == "e" || c == "E") && !nflags_r[1]) begin
                nflags_s[1] = 1'b1; n = 4'd1;
              end else emit = 1'b1;
            end
            M_VIRWS: begin
              if (cc.space) n = 4'd1;
              else mode_s = M_VIRID;
            end
            M_VIRID: begin
              if (cc.letter || cc.digit) n = 4'd1;
              else emit = 1'b1;
            end
            M_IDENT: begin
              if (cc.letter || cc.digit) begin
                n = 4'd1; kp_s = tlbt_pkg::KW_NONE;
              end else emit = 1'b1;
            end
            default: begin
              if (cc.litchar) n = 4'd1;
              else emit = 1'b1;
            end
          endcase
        end
      end
      default: mode_s = M_IDLE;
    endcase
    if (emit) mode_s = M_IDLE;

    // consume: never more than the window holds, offset stops at MAX_TEXT
    n_eff = (5'(n) > 5'(fill_e)) ? 5'(fill_e) : 5'(n);
    for (int i = 0; i < LOOKAHEAD; i++) begin
      win_s[i] = '0;
      for (int k = 0; k <= 10; k++)
        if (n_eff == 5'(k) && i + k < LOOKAHEAD) win_s[i] = win_e[i + k];
    end
    sum   = (OW + 1)'(cur_r) + (OW + 1)'(n_eff);
    cur_s = (sum > (OW + 1)'(MAX_TEXT)) ? OW'(MAX_TEXT) : sum[OW-1:0];
  end

  always_comb begin
    push_req  = pend_v_r && (go ? emit : 1'b1);
    push_last = !go && !fin_e;
    fire      = avail && !(push_req && !res_room);
    res_push  = push_req && fire;
    q_pop     = need_r && fire;
    res_out      = pend_r;
    res_out.last = push_last;

    mode_nxt   = mode_r;
    win_nxt    = win_r;
    fill_nxt   = fill_r;
    ts_nxt     = ts_r;
    cur_nxt    = cur_r;
    nflags_nxt = nflags_r;
    esc_nxt    = esc_r;
    delim_nxt  = delim_r;
    kp_nxt     = kp_r;
    fin_nxt    = fin_r;
    need_nxt   = need_r;
    pend_v_nxt = pend_v_r;
    pend_nxt   = pend_r;

    if (fire) begin
      if (go) begin
        mode_nxt   = mode_s;
        win_nxt    = win_s;
        fill_nxt   = fill_e - FW'(n_eff);
        ts_nxt     = ts_s;
        cur_nxt    = cur_s;
        nflags_nxt = nflags_s;
        esc_nxt    = esc_s;
        delim_nxt  = delim_s;
        kp_nxt     = kp_s;
        fin_nxt    = fin_e;
        need_nxt   = 1'b0;
        if (emit) begin
          pend_v_nxt     = 1'b1;
          pend_nxt.kind  = kind;
          pend_nxt.start = tlbt_pkg::sat16(32'(ts_s));
          pend_nxt.len   = tlbt_pkg::sat16(32'(cur_s - ts_s));
          pend_nxt.last  = 1'b0;
        end
      end else if (fin_e) begin
        // end of text: queue the end token, then start a fresh text
        pend_v_nxt     = 1'b1;
        pend_nxt.kind  = tlbt_pkg::K_END;
        pend_nxt.start = tlbt_pkg::sat16(32'(cur_r));
        pend_nxt.len   = 16'd0;
        pend_nxt.last  = 1'b0;
        mode_nxt   = M_IDLE;
        for (int i = 0; i < LOOKAHEAD; i++) win_nxt[i] = '0;
        fill_nxt   = '0;
        ts_nxt     = '0;
        cur_nxt    = '0;
        nflags_nxt = 2'd0;
        esc_nxt    = 1'b0;
        delim_nxt  = 2'd0;
        kp_nxt     = tlbt_pkg::KW_NONE;
        fin_nxt    = 1'b0;
        need_nxt   = 1'b0;
      end else begin
        // run done: release the held token as last, wait for a byte
        win_nxt    = win_e;
        fill_nxt   = fill_e;
        fin_nxt    = 1'b0;
        need_nxt   = 1'b1;
        pend_v_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= M_IDLE;
      fill_r   <= '0;
      ts_r     <= '0;
      cur_r    <= '0;
      nflags_r <= 2'd0;
      esc_r    <= 1'b0;
      delim_r  <= 2'd0;
      kp_r     <= tlbt_pkg::KW_NONE;
      fin_r    <= 1'b0;
      need_r   <= 1'b1;
      pend_v_r <= 1'b0;
    end else begin
      mode_r   <= mode_nxt;
      fill_r   <= fill_nxt;
      ts_r     <= ts_nxt;
      cur_r    <= cur_nxt;
      nflags_r <= nflags_nxt;
      esc_r    <= esc_nxt;
      delim_r  <= delim_nxt;
      kp_r     <= kp_nxt;
      fin_r    <= fin_nxt;
      need_r   <= need_nxt;
      pend_v_r <= pend_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    win_r  <= win_nxt;
    pend_r <= pend_nxt;
  end

  `TLBT_ASSERT(a_fill_bound, fill_r <= FW'(LOOKAHEAD), "window fill above depth")
  `TLBT_ASSERT(a_offset_order, ts_r <= cur_r && cur_r <= OW'(MAX_TEXT), "offset order broken")
  `TLBT_ASSERT_NEXT(a_end_reset, fire && !go && fin_e,
    cur_r == '0 && fill_r == '0 && pend_v_r && pend_r.kind == tlbt_pkg::K_END,
    "end of text did not restart the text")
  `TLBT_ASSERT_NEXT(a_run_close, fire && !go && !fin_e, need_r && !pend_v_r,
    "run end did not release the held token")

endmodule

/* src/template_language_byte_tokenizer.sv */
// Byte tokenizer: one byte per item, tokens out as kind, start offset, length.
// Throughput: one lexer move per cycle while neither the input nor the token queue stalls.
// Each byte releases its lexer moves and then a step that closes the run; the
// end-of-text byte takes a further step before the close, to queue the end token.
// A byte's token passes the input queue, the lexer's held-token register and the token queue before out_valid.
// Reset: synchronous, active low; clears mode, window fill, offsets and queues.
module template_language_byte_tokenizer #(
  parameter int MAX_TEXT  = 65536,
  parameter int LOOKAHEAD = 10
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_char_byte,
  input  logic        in_end_of_text,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [4:0]  out_token_kind,
  output logic [15:0] out_start_offset,
  output logic [15:0] out_token_length,
  output logic        out_last_of_run
);

  logic               q_valid, q_pop;
  tlbt_pkg::in_item_t q_item;
  logic               res_room, res_push;
  tlbt_pkg::res_t     res_in, head;

  tlbt_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_char_byte   (in_char_byte),
    .in_end_of_text (in_end_of_text),
    .q_valid        (q_valid),
    .q_item         (q_item),
    .q_pop          (q_pop)
  );

  tlbt_back #(
    .MAX_TEXT  (MAX_TEXT),
    .LOOKAHEAD (LOOKAHEAD)
  ) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_valid  (q_valid),
    .q_item   (q_item),
    .q_pop    (q_pop),
    .res_room (res_room),
    .res_push (res_push),
    .res_out  (res_in)
  );

  tlbt_outq u_outq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (res_push),
    .push_res  (res_in),
    .has_room  (res_room),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .head      (head)
  );

  assign out_token_kind   = head.kind;
  assign out_start_offset = head.start;
  assign out_token_length = head.len;
  assign out_last_of_run  = head.last;

endmodule
